// File: rtl/sh24_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh24_pkg
// Shared types, constants and the SipRound function for the SipHash-2-4
// keyed hash block.
// ----------------------------------------------------------------------------
package sh24_pkg;

    localparam logic [63:0] SIP_C0  = 64'h736f6d6570736575;
    localparam logic [63:0] SIP_C1  = 64'h646f72616e646f6d;
    localparam logic [63:0] SIP_C2  = 64'h6c7967656e657261;
    localparam logic [63:0] SIP_C3  = 64'h7465646279746573;
    localparam logic [63:0] SIP_FIN = 64'h00000000000000ff;

    localparam logic [3:0] WORD_BYTES = 4'd8;

    // configuration register indexes
    localparam logic REG_KEY_LOW  = 1'b0;
    localparam logic REG_KEY_HIGH = 1'b1;

    typedef enum logic [1:0] {
        CMD_MID,
        CMD_LAST_FULL,
        CMD_LAST_TAIL
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [3:0]  cnt;
        logic [63:0] word;
    } t_cmd;

    typedef struct packed {
        logic [63:0] v0;
        logic [63:0] v1;
        logic [63:0] v2;
        logic [63:0] v3;
    } t_lanes;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMP,
        ST_FIN,
        ST_DONE
    } t_state;

    function automatic t_lanes sip_round(input t_lanes v);
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] c;
        logic [63:0] d;
        t_lanes      r;
        a = v.v0;
        b = v.v1;
        c = v.v2;
        d = v.v3;
        a = a + b;
        b = {b[50:0], b[63:51]};
        b = b ^ a;
        a = {a[31:0], a[63:32]};
        c = c + d;
        d = {d[47:0], d[63:48]};
        d = d ^ c;
        a = a + d;
        d = {d[42:0], d[63:43]};
        d = d ^ a;
        c = c + b;
        b = {b[46:0], b[63:47]};
        b = b ^ c;
        c = {c[31:0], c[63:32]};
        r.v0 = a;
        r.v1 = b;
        r.v2 = c;
        r.v3 = d;
        return r;
    endfunction

endpackage

// File: rtl/sh24_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh24_front
// Input side: takes message words, saturates the byte count, masks the
// unused tail bytes and tags each word for the round engine.
// ----------------------------------------------------------------------------
module sh24_front (
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [71:0]   s_axis_tdata,   // data_word[63:0], byte_count[67:64], zero pad
    input  logic          s_axis_tlast,
    input  logic          i_full,
    output logic          o_push,
    output sh24_pkg::t_cmd o_cmd
);
    import sh24_pkg::*;

    logic [63:0] w_word;
    logic [3:0]  w_cnt;
    logic [63:0] w_mask;

    assign w_word = s_axis_tdata[63:0];
    assign w_cnt  = (s_axis_tdata[67:64] > WORD_BYTES) ? WORD_BYTES : s_axis_tdata[67:64];

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            w_mask[8*i +: 8] = (4'(i) < w_cnt) ? 8'hff : 8'h00;
        end
    end

    always_comb begin
        o_cmd.cnt = w_cnt;
        if (!s_axis_tlast) begin
            o_cmd.kind = CMD_MID;
            o_cmd.word = w_word;
        end else if (w_cnt == WORD_BYTES) begin
            o_cmd.kind = CMD_LAST_FULL;
            o_cmd.word = w_word;
        end else begin
            o_cmd.kind = CMD_LAST_TAIL;
            o_cmd.word = w_word & w_mask;
        end
    end

    assign s_axis_tready = !i_full;
    assign o_push        = s_axis_tvalid && !i_full;

endmodule

// File: rtl/sh24_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh24_fifo
// Short command queue between the input side and the round engine.
// ----------------------------------------------------------------------------
module sh24_fifo #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sh24_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output sh24_pkg::t_cmd o_cmd
);
    import sh24_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/sh24_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh24_back
// Round engine: one SipRound per cycle on the four lanes, two per word,
// four for finalisation, and the output register.
// ----------------------------------------------------------------------------
module sh24_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [63:0]    i_key_low,
    input  logic [63:0]    i_key_high,
    input  logic           i_empty,
    input  sh24_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [63:0]    m_axis_tdata    // hash_value[63:0]
);
    import sh24_pkg::*;

    t_state      r_state, n_state;
    t_lanes      r_v, n_v;
    logic [63:0] r_m, n_m;
    logic [7:0]  r_len, n_len;
    logic        r_open, n_open;
    logic        r_final, n_final;
    logic        r_lastblk, n_lastblk;
    logic [1:0]  r_rnd, n_rnd;
    logic [63:0] r_hash, n_hash;
    logic        r_out_valid, n_out_valid;

    t_lanes      w_round;
    t_lanes      w_base;
    logic [7:0]  w_len_base;
    logic [7:0]  w_len_tail;

    assign w_round = sip_round(r_v);

    always_comb begin
        if (r_open) begin
            w_base     = r_v;
            w_len_base = r_len;
        end else begin
            w_base.v0  = SIP_C0 ^ i_key_low;
            w_base.v1  = SIP_C1 ^ i_key_high;
            w_base.v2  = SIP_C2 ^ i_key_low;
            w_base.v3  = SIP_C3 ^ i_key_high;
            w_len_base = '0;
        end
        w_len_tail = w_len_base + {4'b0000, i_cmd.cnt};
    end

    assign o_pop = (r_state == ST_IDLE) && !i_empty;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_COMP;
                end
            end
            ST_COMP: begin
                if (r_rnd == 2'd1) begin
                    if (r_lastblk) begin
                        n_state = ST_FIN;
                    end else if (!r_final) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (r_rnd == 2'd3) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!r_out_valid) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_v         = r_v;
        n_m         = r_m;
        n_len       = r_len;
        n_open      = r_open;
        n_final     = r_final;
        n_lastblk   = r_lastblk;
        n_rnd       = r_rnd;
        n_hash      = r_hash;
        n_out_valid = r_out_valid;
        if (m_axis_tvalid && m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    n_v    = w_base;
                    n_open = 1'b1;
                    n_rnd  = '0;
                    if (i_cmd.kind == CMD_LAST_TAIL) begin
                        n_m       = i_cmd.word | {w_len_tail, 56'd0};
                        n_len     = w_len_tail;
                        n_final   = 1'b0;
                        n_lastblk = 1'b1;
                    end else begin
                        n_m       = i_cmd.word;
                        n_len     = w_len_base + 8'd8;
                        n_final   = (i_cmd.kind == CMD_LAST_FULL);
                        n_lastblk = 1'b0;
                    end
                    n_v.v3 = w_base.v3 ^ n_m;
                end
            end
            ST_COMP: begin
                n_v   = w_round;
                n_rnd = r_rnd + 1'b1;
                if (r_rnd == 2'd1) begin
                    n_v.v0 = w_round.v0 ^ r_m;
                    n_rnd  = '0;
                    if (r_lastblk) begin
                        n_v.v2 = w_round.v2 ^ SIP_FIN;
                    end else if (r_final) begin
                        // length-only final block after a full last word
                        n_m       = {r_len, 56'd0};
                        n_v.v3    = w_round.v3 ^ {r_len, 56'd0};
                        n_final   = 1'b0;
                        n_lastblk = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                n_v   = w_round;
                n_rnd = r_rnd + 1'b1;
            end
            ST_DONE: begin
                if (!r_out_valid) begin
                    n_hash      = r_v.v0 ^ r_v.v1 ^ r_v.v2 ^ r_v.v3;
                    n_out_valid = 1'b1;
                    n_open      = 1'b0;
                    n_lastblk   = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_open      <= 1'b0;
            r_final     <= 1'b0;
            r_lastblk   <= 1'b0;
            r_rnd       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_open      <= n_open;
            r_final     <= n_final;
            r_lastblk   <= n_lastblk;
            r_rnd       <= n_rnd;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v    <= n_v;
        r_m    <= n_m;
        r_len  <= n_len;
        r_hash <= n_hash;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_hash;

endmodule

// File: rtl/siphash_2_4_keyed_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// siphash_2_4_keyed_hash
// Flow: each word takes two rounds in ST_COMP; a last word then takes the four
// finalisation rounds in ST_FIN, after a length-only block when it is full.
// Throughput: the single shared SipRound unit takes no new word until it is
// through with the last one; a stalled hash word can hold it in ST_DONE.
// Reset: synchronous active low; clears the queue, the engine and the key to zero.
// ----------------------------------------------------------------------------
module siphash_2_4_keyed_hash #(
    parameter int FIFO_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // data_word[63:0], byte_count[67:64], zero pad
    input  logic        s_axis_tlast,   // last_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // hash_value[63:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import sh24_pkg::*;

    logic [63:0] r_key_low;
    logic [63:0] r_key_high;
    logic        w_full;
    logic        w_empty;
    logic        w_push;
    logic        w_pop;
    t_cmd        w_cmd_in;
    t_cmd        w_cmd_out;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_KEY_HIGH) ? r_key_high : r_key_low;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_low  <= '0;
            r_key_high <= '0;
        end else if (psel && penable && pwrite && pready) begin
            if (paddr[3] == REG_KEY_HIGH) begin
                r_key_high <= pwdata;
            end else begin
                r_key_low <= pwdata;
            end
        end
    end

    sh24_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_full        (w_full),
        .o_push        (w_push),
        .o_cmd         (w_cmd_in)
    );

    sh24_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_cmd   (w_cmd_out)
    );

    sh24_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_key_low     (r_key_low),
        .i_key_high    (r_key_high),
        .i_empty       (w_empty),
        .i_cmd         (w_cmd_out),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: rtl/sh24_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sh24_checker
// Port-level checks for the SipHash-2-4 block, bound to the top level.
// ----------------------------------------------------------------------------
module sh24_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        pready
);

    // after reset the queue is open and no hash is pending
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> (s_axis_tready && !m_axis_tvalid))
        else $error("bad state after reset");

    // a finished hash cannot follow another in the next cycle
    a_result_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready) |=> !m_axis_tvalid)
        else $error("back to back hash words");

    // stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled hash word changed");

    // config port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind siphash_2_4_keyed_hash sh24_checker u_sh24_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .pready        (pready)
);

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the SipHash-2-4 keyed hash block. A short table of
// directed words runs first; four of its hashes are checked against the two
// published vectors for the key 00..0f. Random messages follow under several
// keys, with random idle cycles on the input and output streams. A long output
// stall fills the block and stalls its input. Every hash word is checked, in
// order, against its table vector or an in-bench model of lanes and length byte.
// ----------------------------------------------------------------------------
module tb_top;
    import sh24_pkg::*;

    localparam int          RX_HOLD_CYCLES = 300;
    localparam int          SETTLE_CYCLES  = 24;
    localparam int          PHASE_WORDS    = 250;
    localparam logic [3:0]  ADDR_KEY_LOW   = {REG_KEY_LOW, 3'b000};
    localparam logic [3:0]  ADDR_KEY_HIGH  = {REG_KEY_HIGH, 3'b000};
    localparam logic [63:0] VEC_KEY_LOW    = 64'h0706050403020100;
    localparam logic [63:0] VEC_KEY_HIGH   = 64'h0f0e0d0c0b0a0908;
    localparam logic [63:0] VEC_EMPTY      = 64'h726fdb47dd0e0e31;
    localparam logic [63:0] VEC_15_BYTES   = 64'ha129ca6149be45e5;
    localparam logic [63:0] ALL_ONES       = 64'hffffffffffffffff;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // data_word[63:0], byte_count[67:64], zero pad
    logic        s_axis_tlast;   // last_word
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // hash_value[63:0]
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    siphash_2_4_keyed_hash u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    typedef struct {
        logic [63:0] word;
        logic [3:0]  cnt;
        logic        last;
        bit          known;
        logic [63:0] hv;
    } t_row;

    // model state
    logic [63:0] key_k0;
    logic [63:0] key_k1;
    logic [63:0] st_v0;
    logic [63:0] st_v1;
    logic [63:0] st_v2;
    logic [63:0] st_v3;
    logic [7:0]  byte_len;
    bit          in_msg;

    logic [63:0] hash_q[$];
    int          err_count;
    int          words_sent;
    int          hashes_checked;
    int          key_sets;
    bit          no_gaps;
    bit          rx_hold;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("timeout: %0d hash words outstanding", hash_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t: %s got %016h want %016h", $realtime, what, got, want);
        err_count++;
    endtask

    function automatic logic [63:0] rotl(input logic [63:0] x, input int b);
        return (x << b) | (x >> (64 - b));
    endfunction

    function automatic void sip_mix();
        st_v0 = st_v0 + st_v1;
        st_v1 = rotl(st_v1, 13) ^ st_v0;
        st_v0 = rotl(st_v0, 32);
        st_v2 = st_v2 + st_v3;
        st_v3 = rotl(st_v3, 16) ^ st_v2;
        st_v0 = st_v0 + st_v3;
        st_v3 = rotl(st_v3, 21) ^ st_v0;
        st_v2 = st_v2 + st_v1;
        st_v1 = rotl(st_v1, 17) ^ st_v2;
        st_v2 = rotl(st_v2, 32);
    endfunction

    function automatic void absorb_block(input logic [63:0] m);
        st_v3 = st_v3 ^ m;
        sip_mix();
        sip_mix();
        st_v0 = st_v0 ^ m;
    endfunction

    // advances the lanes by one word; returns 1 with the hash on a last word
    function automatic bit predict_hash(input logic [63:0] w, input logic [3:0] c,
                                        input logic l, output logic [63:0] hv);
        logic [63:0] tail;
        tail = '0;
        hv   = '0;
        if (!in_msg) begin
            st_v0    = SIP_C0 ^ key_k0;
            st_v1    = SIP_C1 ^ key_k1;
            st_v2    = SIP_C2 ^ key_k0;
            st_v3    = SIP_C3 ^ key_k1;
            byte_len = '0;
            in_msg   = 1'b1;
        end
        if (!l || c >= WORD_BYTES) begin
            absorb_block(w);
            byte_len = byte_len + 8'd8;
            if (!l) begin
                return 1'b0;
            end
        end else begin
            for (int i = 0; i < c; i++) begin
                tail[8*i +: 8] = w[8*i +: 8];
            end
            byte_len = byte_len + {4'd0, c};
        end
        absorb_block(tail | {byte_len, 56'd0});
        st_v2 = st_v2 ^ SIP_FIN;
        repeat (4) sip_mix();
        hv     = st_v0 ^ st_v1 ^ st_v2 ^ st_v3;
        in_msg = 1'b0;
        return 1'b1;
    endfunction

    task automatic apb_write(input logic [3:0] addr, input logic [63:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_KEY_LOW) begin
            key_k0 = val;
        end else begin
            key_k1 = val;
        end
        @(posedge i_clk);
    endtask

    task automatic set_key(input logic [63:0] k0, input logic [63:0] k1);
        apb_write(ADDR_KEY_LOW, k0);
        apb_write(ADDR_KEY_HIGH, k1);
        key_sets++;
    endtask

    task automatic send_word(input logic [63:0] w, input logic [3:0] c, input logic l,
                             input bit known, input logic [63:0] known_hv);
        int          gap;
        logic [63:0] hv;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, c, w};
        s_axis_tlast  <= l;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
        if (predict_hash(w, c, l, hv)) begin
            hash_q.push_back(known ? known_hv : hv);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (hash_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_word();
        int sel;
        sel = $urandom_range(0, 15);
        if (sel == 0) begin
            return '0;
        end else if (sel == 1) begin
            return ALL_ONES;
        end
        return {$urandom, $urandom};
    endfunction

    task automatic send_message(input int n_words);
        int         r;
        logic [3:0] c;
        for (int i = 0; i < n_words - 1; i++) begin
            send_word(rand_word(), 4'($urandom_range(0, 15)), 1'b0, 1'b0, '0);
        end
        r = $urandom_range(0, 9);
        c = (r <= 8) ? 4'(r) : 4'($urandom_range(9, 15));
        send_word(rand_word(), c, 1'b1, 1'b0, '0);
    endtask

    function automatic int rand_msg_words();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return $urandom_range(1, 4);
        end else if (r < 95) begin
            return $urandom_range(5, 12);
        end
        // long enough for the length byte to wrap
        return $urandom_range(33, 40);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (hash_q.size() == 0) begin
                report_mismatch("hash word with none expected", m_axis_tdata, '0);
            end else begin
                if (m_axis_tdata !== hash_q[0]) begin
                    report_mismatch("hash_value", m_axis_tdata, hash_q[0]);
                end
                void'(hash_q.pop_front());
            end
            hashes_checked++;
        end
    end

    initial begin : rx_side
        int wait_cyc;
        m_axis_tready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            wait_cyc = no_gaps ? 0 : $urandom_range(0, 4);
            if (rx_hold) begin
                wait_cyc = RX_HOLD_CYCLES;
                rx_hold  = 1'b0;
            end
            if (wait_cyc > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_cyc) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin : stim
        t_row        rows[$];
        logic [63:0] keys_k0[6];
        logic [63:0] keys_k1[6];
        int          phase_start;

        err_count      = 0;
        words_sent     = 0;
        hashes_checked = 0;
        key_sets       = 0;
        no_gaps        = 1'b0;
        rx_hold        = 1'b0;
        key_k0         = '0;
        key_k1         = '0;
        st_v0          = '0;
        st_v1          = '0;
        st_v2          = '0;
        st_v3          = '0;
        byte_len       = '0;
        in_msg         = 1'b0;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset key, before any register write
        send_word('0, 4'd0, 1'b1, 1'b0, '0);
        send_word(ALL_ONES, 4'd8, 1'b1, 1'b0, '0);
        drain();

        rows = '{
            '{64'h0, 4'd0, 1'b1, 1'b1, VEC_EMPTY},
            '{64'h0706050403020100, 4'd8, 1'b0, 1'b0, 64'h0},
            '{64'h000e0d0c0b0a0908, 4'd7, 1'b1, 1'b1, VEC_15_BYTES},
            '{ALL_ONES, 4'd0, 1'b1, 1'b1, VEC_EMPTY},
            '{ALL_ONES, 4'd8, 1'b1, 1'b0, 64'h0},
            '{64'h0, 4'd15, 1'b1, 1'b0, 64'h0},
            '{ALL_ONES, 4'd9, 1'b1, 1'b0, 64'h0},
            '{ALL_ONES, 4'd0, 1'b0, 1'b0, 64'h0},
            '{ALL_ONES, 4'd1, 1'b1, 1'b0, 64'h0},
            '{64'h0, 4'd15, 1'b0, 1'b0, 64'h0},
            '{64'h0706050403020100, 4'd8, 1'b1, 1'b0, 64'h0},
            '{64'h0706050403020100, 4'd3, 1'b0, 1'b0, 64'h0},
            '{64'hff0e0d0c0b0a0908, 4'd7, 1'b1, 1'b1, VEC_15_BYTES},
            '{ALL_ONES, 4'd7, 1'b1, 1'b0, 64'h0},
            '{64'h8000000000000001, 4'd4, 1'b0, 1'b0, 64'h0},
            '{64'h8000000000000001, 4'd2, 1'b1, 1'b0, 64'h0}
        };
        set_key(VEC_KEY_LOW, VEC_KEY_HIGH);
        foreach (rows[i]) begin
            send_word(rows[i].word, rows[i].cnt, rows[i].last, rows[i].known, rows[i].hv);
        end
        drain();

        keys_k0 = '{64'h0, ALL_ONES, 64'h0, ALL_ONES, {$urandom, $urandom}, {$urandom, $urandom}};
        keys_k1 = '{64'h0, ALL_ONES, ALL_ONES, 64'h0, {$urandom, $urandom}, {$urandom, $urandom}};
        for (int p = 0; p < 6; p++) begin
            set_key(keys_k0[p], keys_k1[p]);
            no_gaps     = (p == 1);
            phase_start = words_sent;
            while (words_sent - phase_start < PHASE_WORDS) begin
                send_message(rand_msg_words());
                if (p == 2 && words_sent - phase_start > PHASE_WORDS / 2 && !rx_hold) begin
                    // output held off while empty messages keep arriving back to back
                    rx_hold = 1'b1;
                    no_gaps = 1'b1;
                    repeat (40) send_word(rand_word(), 4'd0, 1'b1, 1'b0, '0);
                    no_gaps = 1'b0;
                    rx_hold = 1'b1;
                end
                if (p == 3 && $urandom_range(0, 19) == 0) begin
                    drain();
                end
            end
            drain();
        end
        no_gaps = 1'b0;

        $display("covered %0d words and %0d hashes under %0d key settings",
                 words_sent, hashes_checked, key_sets);
        $display("including empty, tail, saturated count and length-wrap messages");
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches", err_count);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
